FILE: rtl/assert_macros.svh
// Assertion macros for the classifier RTL, used by odtc_track.
// Needs clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/odtc_pkg.sv
// Package for the open-descriptor transport classifier: sizes, codes,
// prefix tables and the transaction structs. No dependencies.
package odtc_pkg;

    localparam int MAX_LEN = 1024;
    localparam int POS_W   = $clog2(MAX_LEN + 1);
    localparam int CHAR_W  = 8;
    localparam int START_W = 4;
    localparam int PLEN_W  = 11;

    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_LEN);

    typedef enum logic [1:0] {
        TR_IPC      = 2'd0,
        TR_FILE     = 2'd1,
        TR_FIFO     = 2'd2,
        TR_FIFO_BAD = 2'd3
    } transport_t;

    localparam int PF_FIFO1 = 0;
    localparam int PF_FIFO2 = 1;
    localparam int PF_UNIXS = 2;
    localparam int PF_UNIX  = 3;
    localparam int PF_TCPS  = 4;
    localparam int PF_COUNT = 5;

    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    localparam logic [CHAR_W-1:0] PREFIX_CHARS [PF_COUNT][8] = '{
        '{"f", "i", "f", "o", ":", 8'h00, 8'h00, 8'h00},
        '{"f", "i", "f", "o", ":", "/", "/", 8'h00},
        '{"u", "n", "i", "x", "s", ":", "/", "/"},
        '{"u", "n", "i", "x", ":", "/", "/", 8'h00},
        '{"t", "c", "p", "s", ":", "/", "/", 8'h00}
    };

    localparam logic [3:0] PREFIX_LEN [PF_COUNT] = '{4'd5, 4'd7, 4'd8, 4'd7, 4'd7};

    // Offset past "fifo://"
    localparam logic [START_W-1:0] FIFO_SKIP = 4'd7;

    typedef struct packed {
        logic [CHAR_W-1:0] char_byte;
        logic              is_final;
    } item_t;

    typedef struct packed {
        transport_t         transport;
        logic [START_W-1:0] path_start;
        logic [PLEN_W-1:0]  path_length;
        logic               too_long;
    } result_t;

endpackage

FILE: rtl/open_descriptor_transport_classifier.sv
// Channel | handshake            | payload
// in      | in_valid / in_ready   | char_byte, is_final
// out     | out_valid / out_ready | transport, path_start, path_length, too_long
// One byte per cycle unless a final byte waits: input register, flag update and
// classification, result register, which is loaded from the final byte's classification.
// Non-final bytes advance while a result waits; a final byte holds until the result
// register is free. Asynchronous active-low reset clears all flags and valid bits.
// Depends on odtc_pkg, odtc_in_reg, odtc_track, odtc_out_reg.
module open_descriptor_transport_classifier (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [odtc_pkg::CHAR_W-1:0]  char_byte,
    input  logic                         is_final,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   transport,
    output logic [odtc_pkg::START_W-1:0] path_start,
    output logic [odtc_pkg::PLEN_W-1:0]  path_length,
    output logic                         too_long
);
    import odtc_pkg::*;

    item_t   in_item;
    item_t   hold_item;
    logic    hold_valid;
    logic    out_free;
    logic    step;
    result_t step_result;
    result_t held;

    assign in_item.char_byte = char_byte;
    assign in_item.is_final  = is_final;

    assign step = hold_valid && (!hold_item.is_final || out_free);

    odtc_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .take       (step),
        .hold_valid (hold_valid),
        .hold_item  (hold_item)
    );

    odtc_track u_track (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (hold_item),
        .result (step_result)
    );

    odtc_out_reg u_out_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (step && hold_item.is_final),
        .load_result (step_result),
        .free        (out_free),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .held        (held)
    );

    assign transport   = held.transport;
    assign path_start  = held.path_start;
    assign path_length = held.path_length;
    assign too_long    = held.too_long;

endmodule

FILE: rtl/odtc_in_reg.sv
// Input register of the classifier: holds one accepted byte transaction.
// Depends on odtc_pkg.
module odtc_in_reg (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  odtc_pkg::item_t in_item,
    input  logic            take,
    output logic            hold_valid,
    output odtc_pkg::item_t hold_item
);
    import odtc_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !take);
    assign hold_valid = valid_reg;
    assign hold_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

FILE: rtl/odtc_track.sv
// Running descriptor flags and the classification of the final byte.
// Depends on odtc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module odtc_track (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  odtc_pkg::item_t   item,
    output odtc_pkg::result_t result
);
    import odtc_pkg::*;

    logic [POS_W-1:0]    pos_reg, pos_next;
    logic                lead_reg, lead_next;
    logic                dbl_reg, dbl_next;
    logic [PF_COUNT-1:0] pf_reg, pf_next;
    logic                digits_reg, digits_next;
    logic                fcs_reg, fcs_next;
    logic                pfd_reg, pfd_next;
    logic                pfne_reg, pfne_next;
    logic                pfdig_reg, pfdig_next;
    logic                ovf_reg, ovf_next;

    logic             pos_sat;
    logic             lead_hit;
    logic             is_colon;
    logic             is_num;
    logic [POS_W-1:0] ri;
    logic             ri_small;
    logic [2:0]       ri_idx;
    logic [POS_W-1:0] rn;
    logic             hit_fifo1, hit_fifo2, hit_ipc_pfx;
    logic             flags_idle;

    assign pos_sat  = (pos_reg == MAX_POS);
    assign is_colon = (item.char_byte == CH_COLON);
    assign is_num   = (item.char_byte >= CH_ZERO) && (item.char_byte <= CH_NINE);
    assign lead_hit = (pos_reg == '0) && is_colon;
    assign ri       = pos_reg - POS_W'(lead_reg);
    assign ri_small = (ri < POS_W'(8));
    assign ri_idx   = ri[2:0];

    always_comb
    begin
        pos_next    = pos_sat ? pos_reg : pos_reg + POS_W'(1);
        ovf_next    = ovf_reg || pos_sat;
        lead_next   = lead_reg || lead_hit;
        dbl_next    = dbl_reg || ((pos_reg == POS_W'(1)) && lead_reg && is_colon);
        pf_next     = pf_reg;
        digits_next = digits_reg;
        fcs_next    = fcs_reg;
        pfd_next    = pfd_reg;
        pfne_next   = pfne_reg;
        pfdig_next  = pfdig_reg;
        if (!lead_hit)
        begin
            for (int k = 0; k < PF_COUNT; k++)
            begin
                if (ri_small && ({1'b0, ri_idx} < PREFIX_LEN[k])
                    && (item.char_byte != PREFIX_CHARS[k][ri_idx]))
                begin
                    pf_next[k] = 1'b0;
                end
            end
            if (!is_num)
            begin
                digits_next = 1'b0;
            end
            if (!fcs_reg)
            begin
                fcs_next = is_colon;
            end
            else if (!pfd_reg)
            begin
                if (is_colon)
                begin
                    pfd_next = 1'b1;
                end
                else
                begin
                    pfne_next = 1'b1;
                    if (!is_num)
                    begin
                        pfdig_next = 1'b0;
                    end
                end
            end
        end
    end

    assign rn          = pos_next - POS_W'(lead_next);
    assign hit_fifo1   = pf_next[PF_FIFO1] && (rn >= POS_W'(PREFIX_LEN[PF_FIFO1]));
    assign hit_fifo2   = pf_next[PF_FIFO2] && (rn >= POS_W'(PREFIX_LEN[PF_FIFO2]));
    assign hit_ipc_pfx = (pf_next[PF_UNIXS] && (rn >= POS_W'(PREFIX_LEN[PF_UNIXS])))
                      || (pf_next[PF_UNIX] && (rn >= POS_W'(PREFIX_LEN[PF_UNIX])))
                      || (pf_next[PF_TCPS] && (rn >= POS_W'(PREFIX_LEN[PF_TCPS])));

    always_comb
    begin
        result.too_long    = ovf_next;
        result.transport   = TR_FILE;
        result.path_start  = START_W'(lead_next);
        result.path_length = PLEN_W'(rn);
        if (dbl_next)
        begin
            result.transport   = TR_IPC;
            result.path_start  = '0;
            result.path_length = PLEN_W'(pos_next);
        end
        else if (hit_fifo1)
        begin
            if (hit_fifo2)
            begin
                result.transport   = TR_FIFO;
                result.path_start  = FIFO_SKIP + START_W'(lead_next);
                result.path_length = PLEN_W'(rn - POS_W'(FIFO_SKIP));
            end
            else
            begin
                result.transport   = TR_FIFO_BAD;
                result.path_start  = '0;
                result.path_length = PLEN_W'(pos_next);
            end
        end
        else if (hit_ipc_pfx || ((rn != '0) && digits_next)
                 || (fcs_next && pfne_next && pfdig_next))
        begin
            result.transport   = TR_IPC;
            result.path_start  = '0;
            result.path_length = PLEN_W'(pos_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            lead_reg   <= 1'b0;
            dbl_reg    <= 1'b0;
            pf_reg     <= '1;
            digits_reg <= 1'b1;
            fcs_reg    <= 1'b0;
            pfd_reg    <= 1'b0;
            pfne_reg   <= 1'b0;
            pfdig_reg  <= 1'b1;
            ovf_reg    <= 1'b0;
        end
        else if (step)
        begin
            if (item.is_final)
            begin
                pos_reg    <= '0;
                lead_reg   <= 1'b0;
                dbl_reg    <= 1'b0;
                pf_reg     <= '1;
                digits_reg <= 1'b1;
                fcs_reg    <= 1'b0;
                pfd_reg    <= 1'b0;
                pfne_reg   <= 1'b0;
                pfdig_reg  <= 1'b1;
                ovf_reg    <= 1'b0;
            end
            else
            begin
                pos_reg    <= pos_next;
                lead_reg   <= lead_next;
                dbl_reg    <= dbl_next;
                pf_reg     <= pf_next;
                digits_reg <= digits_next;
                fcs_reg    <= fcs_next;
                pfd_reg    <= pfd_next;
                pfne_reg   <= pfne_next;
                pfdig_reg  <= pfdig_next;
                ovf_reg    <= ovf_next;
            end
        end
    end

    assign flags_idle = (pos_reg == '0) && !ovf_reg && (pf_reg == '1) && !lead_reg;

    `ASSERT_IMPL(a_pos_bound, 1'b1, pos_reg <= MAX_POS, "byte count beyond limit")
    `ASSERT_IMPL(a_ovf_saturated, ovf_reg, pos_reg == MAX_POS, "overflow without saturation")
    `ASSERT_NEXT(a_clear_after_final, step && item.is_final, flags_idle, "flags not cleared")

endmodule

FILE: rtl/odtc_out_reg.sv
// Result register of the classifier: holds one result transaction until taken.
// Depends on odtc_pkg.
module odtc_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  odtc_pkg::result_t load_result,
    output logic              free,
    output logic              out_valid,
    input  logic              out_ready,
    output odtc_pkg::result_t held
);
    import odtc_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign free       = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);
    assign out_valid  = valid_reg;
    assign held       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= load_result;
        end
    end

endmodule

FILE: bench/tb.sv
// Testbench for open_descriptor_transport_classifier: streams descriptor bytes, predicts
// each transport classification and checks every result transaction field by field.
// Depends on odtc_pkg and the classifier RTL.
module tb;
    import odtc_pkg::*;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [CHAR_W-1:0]  char_byte = '0;
    logic               is_final = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         transport;
    logic [START_W-1:0] path_start;
    logic [PLEN_W-1:0]  path_length;
    logic               too_long;

    item_t             byte_queue[$];
    logic [CHAR_W-1:0] draft[$];
    result_t           awaited_results[$];

    int sender_idle_pct = 0;
    int recv_stall_pct = 0;
    int bytes_loaded = 0;
    int bytes_taken = 0;
    int descriptors_checked = 0;
    int error_count = 0;

    int unsigned       seen_count;
    bit                lead_col;
    bit                dbl_col;
    bit                body_digits;
    bit                colon_found;
    bit                port_closed;
    bit                port_has_chars;
    bit                port_digits;
    bit                saturated;
    bit [PF_COUNT-1:0] prefix_alive;

    open_descriptor_transport_classifier dut (.*);

    always #5 clk = ~clk;

    function automatic string prefix_of(int k);
        case (k)
            PF_FIFO1: return "fifo:";
            PF_FIFO2: return "fifo://";
            PF_UNIXS: return "unixs://";
            PF_UNIX:  return "unix://";
            default:  return "tcps://";
        endcase
    endfunction

    function automatic bit is_digit_char(logic [CHAR_W-1:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    task automatic clear_descriptor_state();
        seen_count = 0;
        lead_col = 1'b0;
        dbl_col = 1'b0;
        prefix_alive = '1;
        body_digits = 1'b1;
        colon_found = 1'b0;
        port_closed = 1'b0;
        port_has_chars = 1'b0;
        port_digits = 1'b1;
        saturated = 1'b0;
    endtask

    task automatic take_descriptor_byte(input logic [CHAR_W-1:0] c, input logic fin);
        int unsigned pos;
        int unsigned rel;
        int unsigned n;
        int unsigned off;
        int unsigned rn;
        string       p;
        bit          to_ipc;
        result_t     r;
        pos = seen_count;
        if (pos >= MAX_LEN)
            saturated = 1'b1;
        else
            seen_count = pos + 1;
        if (pos == 0 && c == CH_COLON)
            lead_col = 1'b1;
        else
        begin
            if (pos == 1 && lead_col && c == CH_COLON)
                dbl_col = 1'b1;
            rel = pos - lead_col;
            for (int k = 0; k < PF_COUNT; k++)
            begin
                p = prefix_of(k);
                if (rel < p.len() && c != p[rel])
                    prefix_alive[k] = 1'b0;
            end
            if (!is_digit_char(c))
                body_digits = 1'b0;
            if (!colon_found)
            begin
                if (c == CH_COLON)
                    colon_found = 1'b1;
            end
            else if (!port_closed)
            begin
                if (c == CH_COLON)
                    port_closed = 1'b1;
                else
                begin
                    port_has_chars = 1'b1;
                    if (!is_digit_char(c))
                        port_digits = 1'b0;
                end
            end
        end
        if (fin)
        begin
            n = seen_count;
            off = lead_col;
            rn = n - off;
            to_ipc = 1'b0;
            r.transport = TR_FILE;
            r.path_start = START_W'(off);
            r.path_length = PLEN_W'(rn);
            if (dbl_col)
                to_ipc = 1'b1;
            else if (prefix_alive[PF_FIFO1] && rn >= PREFIX_LEN[PF_FIFO1])
            begin
                if (prefix_alive[PF_FIFO2] && rn >= PREFIX_LEN[PF_FIFO2])
                begin
                    r.transport = TR_FIFO;
                    r.path_start = START_W'(off + 7);
                    r.path_length = PLEN_W'(rn - 7);
                end
                else
                begin
                    r.transport = TR_FIFO_BAD;
                    r.path_start = '0;
                    r.path_length = PLEN_W'(n);
                end
            end
            else if ((prefix_alive[PF_UNIXS] && rn >= PREFIX_LEN[PF_UNIXS]) ||
                     (prefix_alive[PF_UNIX] && rn >= PREFIX_LEN[PF_UNIX]) ||
                     (prefix_alive[PF_TCPS] && rn >= PREFIX_LEN[PF_TCPS]))
                to_ipc = 1'b1;
            else if (rn > 0 && body_digits)
                to_ipc = 1'b1;
            else if (colon_found && port_has_chars && port_digits)
                to_ipc = 1'b1;
            if (to_ipc)
            begin
                r.transport = TR_IPC;
                r.path_start = '0;
                r.path_length = PLEN_W'(n);
            end
            r.too_long = saturated;
            awaited_results.push_back(r);
            clear_descriptor_state();
        end
    endtask

    task automatic put_byte(input logic [CHAR_W-1:0] b);
        draft.push_back(b);
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++)
            draft.push_back(s[i]);
    endtask

    task automatic put_digits(input int n);
        repeat (n) put_byte(CH_ZERO + CHAR_W'($urandom_range(0, 9)));
    endtask

    task automatic put_word(input int n);
        repeat (n) put_byte(8'h61 + CHAR_W'($urandom_range(0, 25)));
    endtask

    task automatic put_path(input int n);
        repeat (n)
        begin
            case ($urandom_range(0, 9))
                6:       put_digits(1);
                7:       put_byte("/");
                8:       put_byte(".");
                9:       put_byte(CH_COLON);
                default: put_word(1);
            endcase
        end
    endtask

    task automatic commit_descriptor();
        item_t it;
        if (draft.size() == 0)
            put_word(1);
        foreach (draft[i])
        begin
            it.char_byte = draft[i];
            it.is_final = (i == draft.size() - 1);
            byte_queue.push_back(it);
        end
        bytes_loaded += draft.size();
        draft.delete();
    endtask

    task automatic load_text(input string s);
        put_str(s);
        commit_descriptor();
    endtask

    task automatic make_random_descriptor();
        string p;
        int    j;
        int    lead;
        lead = $urandom_range(0, 9);
        if (lead == 8)
            put_byte(CH_COLON);
        else if (lead == 9)
            put_str("::");
        case ($urandom_range(0, 9))
            0, 1:
            begin
                p = prefix_of($urandom_range(0, PF_COUNT - 1));
                if ($urandom_range(0, 3) == 0)
                    p = p.substr(0, $urandom_range(0, p.len() - 1));
                put_str(p);
                put_path($urandom_range(0, 12));
            end
            2: put_digits($urandom_range(1, 8));
            3, 4:
            begin
                put_word($urandom_range(0, 6));
                put_byte(CH_COLON);
                put_digits($urandom_range(0, 5));
                if ($urandom_range(0, 3) == 0)
                    put_word(1);
                if ($urandom_range(0, 2) == 0)
                begin
                    put_byte(CH_COLON);
                    put_path($urandom_range(0, 6));
                end
            end
            5:
            begin
                put_byte("/");
                put_path($urandom_range(0, 16));
            end
            6:
            begin
                repeat ($urandom_range(1, 12))
                    put_byte($urandom_range(0, 3) == 0 ? CH_COLON
                                                       : CHAR_W'($urandom_range(0, 255)));
            end
            7:
            begin
                p = prefix_of($urandom_range(0, PF_COUNT - 1));
                j = $urandom_range(0, p.len() - 1);
                for (int i = 0; i < p.len(); i++)
                    put_byte(i == j ? CHAR_W'($urandom_range(0, 255)) : CHAR_W'(p[i]));
                put_path($urandom_range(0, 8));
            end
            8: put_byte($urandom_range(0, 1) ? CH_COLON : CHAR_W'($urandom_range(0, 255)));
            default:
            begin
                put_digits($urandom_range(1, 4));
                put_byte(CH_COLON);
                put_path($urandom_range(0, 6));
            end
        endcase
        if ($urandom_range(0, 19) == 0)
            put_path($urandom_range(20, 60));
        commit_descriptor();
    endtask

    task automatic wait_for_drain();
        while (bytes_taken != bytes_loaded || awaited_results.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin : drive_bytes
        item_t next_item;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_ready)
        begin
            if (byte_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
            begin
                next_item = byte_queue.pop_front();
                in_valid <= 1'b1;
                char_byte <= next_item.char_byte;
                is_final <= next_item.is_final;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            bytes_taken++;
            take_descriptor_byte(char_byte, is_final);
        end
    end

    always @(posedge clk)
    begin : check_result
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("unexpected result: transport %0d path_start %0d path_length %0d",
                       transport, path_start, path_length);
                error_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                descriptors_checked++;
                if (transport !== want.transport)
                begin
                    $error("transport: expected %0d, got %0d", want.transport, transport);
                    error_count++;
                end
                if (path_start !== want.path_start)
                begin
                    $error("path_start: expected %0d, got %0d", want.path_start, path_start);
                    error_count++;
                end
                if (path_length !== want.path_length)
                begin
                    $error("path_length: expected %0d, got %0d", want.path_length, path_length);
                    error_count++;
                end
                if (too_long !== want.too_long)
                begin
                    $error("too_long: expected %0d, got %0d", want.too_long, too_long);
                    error_count++;
                end
            end
        end
    end

    initial
    begin : stimulus
        int target;
        clear_descriptor_state();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        load_text(":");
        load_text("::");
        load_text("::abc");
        load_text("fifo://p");
        load_text(":fifo://tmp/q");
        load_text("fifo:x");
        load_text(":fifo:");
        load_text("fifo:/");
        load_text("fifo");
        load_text("unixs://s");
        load_text("unix://");
        load_text(":tcps://h");
        load_text("tcps:/");
        load_text("12345");
        load_text(":0");
        load_text("host:8080");
        load_text("host:80:x");
        load_text("host::");
        load_text("host:8a");
        load_text("/var/log/x");
        put_byte(8'hFF);
        commit_descriptor();
        put_byte(8'h00);
        commit_descriptor();
        wait_for_drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    sender_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct = 58;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    recv_stall_pct = 58;
                end
                default:
                begin
                    sender_idle_pct = 34;
                    recv_stall_pct = 34;
                end
            endcase
            target = bytes_loaded + 205;
            while (bytes_loaded < target)
                make_random_descriptor();
            wait_for_drain();
        end

        repeat (8) @(posedge clk);
        $display("summary: %0d descriptor bytes sent, %0d classifications checked,",
                 bytes_taken, descriptors_checked);
        $display("summary: directed corners, random descriptors and four flow-control mixes");
        if (error_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("tb: errors");
        $finish;
    end

endmodule
